// ===== rtl/dst_pkg.sv =====
// shared types and constants for the descriptor slot table
package dst_pkg;

    localparam int DST_NUM_SLOTS     = 16;
    localparam int DST_CONSOLE_SLOTS = 3;
    localparam int DST_WORD_W        = 32;
    localparam int DST_SLOT_OUT_W    = 4;

    localparam logic [2:0] REQ_LOOKUP       = 3'd0;
    localparam logic [2:0] REQ_ALLOC_FILE   = 3'd1;
    localparam logic [2:0] REQ_ALLOC_SOCKET = 3'd2;
    localparam logic [2:0] REQ_CLOSE        = 3'd3;
    localparam logic [2:0] REQ_REINIT       = 3'd4;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_CONSOLE = 2'd1;
    localparam logic [1:0] KIND_FILE    = 2'd2;
    localparam logic [1:0] KIND_SOCKET  = 2'd3;

    localparam logic [DST_WORD_W-1:0] WORD_NEG_ONE = '1;
    localparam logic [DST_WORD_W-1:0] WORD_ZERO    = '0;

    // payload memory word: file keeps node and flags, socket keeps its id
    typedef struct packed {
        logic                  is_socket;
        logic [DST_WORD_W-1:0] word_a;
        logic [DST_WORD_W-1:0] word_b;
    } dst_entry_t;

    typedef struct packed {
        logic                      status;
        logic [DST_SLOT_OUT_W-1:0] slot_result;
        logic [1:0]                entry_kind;
        logic [DST_WORD_W-1:0]     node_out;
        logic [DST_WORD_W-1:0]     socket_out;
        logic [DST_WORD_W-1:0]     flags_out;
        logic                      release_socket;
    } dst_rsp_t;

endpackage

// ===== rtl/dst_if.sv =====
// request and result channel interfaces of the descriptor slot table
interface dst_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic signed [7:0]  slot_number;
    logic signed [31:0] node_value;
    logic signed [31:0] socket_number;
    logic [31:0]        open_flags;

    modport source (
        output valid, req_type, slot_number, node_value, socket_number, open_flags,
        input  ready
    );
    modport sink (
        input  valid, req_type, slot_number, node_value, socket_number, open_flags,
        output ready
    );
endinterface

interface dst_rsp_if;
    logic               valid;
    logic               ready;
    logic               status;
    logic [3:0]         slot_result;
    logic [1:0]         entry_kind;
    logic signed [31:0] node_out;
    logic signed [31:0] socket_out;
    logic [31:0]        flags_out;
    logic               release_socket;

    modport source (
        output valid, status, slot_result, entry_kind, node_out, socket_out,
               flags_out, release_socket,
        input  ready
    );
    modport sink (
        input  valid, status, slot_result, entry_kind, node_out, socket_out,
               flags_out, release_socket,
        output ready
    );
endinterface

// ===== rtl/dst_free_enc.sv =====
// lowest free slot priority encoder
module dst_free_enc
    import dst_pkg::*;
#(
    parameter int NUM_SLOTS = DST_NUM_SLOTS,
    localparam int IDX_W = $clog2(NUM_SLOTS)
)(
    input  logic [NUM_SLOTS-1:0] used,
    output logic                 found,
    output logic [IDX_W-1:0]     idx
);

    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        // scan from the top so the lowest free slot wins
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!used[i])
            begin
                found = 1'b1;
                idx   = IDX_W'(i);
            end
        end
    end

endmodule

// ===== rtl/dst_slot_mem.sv =====
// payload memory of the slot table, one write and one registered read port
module dst_slot_mem
    import dst_pkg::*;
#(
    parameter int NUM_SLOTS = DST_NUM_SLOTS,
    localparam int IDX_W = $clog2(NUM_SLOTS)
)(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  dst_entry_t       wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output dst_entry_t       rd_data
);

    dst_entry_t mem [NUM_SLOTS];
    dst_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/descriptor_slot_table.sv =====
// descriptor slot table top level
// A table of NUM_SLOTS descriptor slots (16 by default) that takes one request per
// transfer and gives exactly one result transfer for it: lookup, allocate file,
// allocate socket (both take the lowest free slot), close and reinitialize. A new
// request can be taken in every clock cycle while results are being taken. A request
// taken sits in the stage register, which also holds the payload memory read;
// from there its result moves to the output register, which offers it as the
// result transfer. The payload memory has a single write and a single read port,
// and the lowest-free priority encoder over the flop-held use bits is combinational.
// Use bits and console marks live in flops and come out of reset with slots 0 to 2
// used as console, so there is no clearing pass; the payload memory has no reset
// because its contents are used only for slots that an allocate has written.
// While a finished result waits in the output register the stage register holds,
// so the input then takes a request only into an empty stage register; at most
// two requests are in flight.
module descriptor_slot_table
    import dst_pkg::*;
#(
    parameter int NUM_SLOTS = DST_NUM_SLOTS
)(
    input  logic      clk,
    input  logic      rst_n,
    dst_req_if.sink   req,
    dst_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam logic [NUM_SLOTS-1:0] INIT_MASK = NUM_SLOTS'((1 << DST_CONSOLE_SLOTS) - 1);

    // slot state in flops
    logic [NUM_SLOTS-1:0] used_reg, used_next;
    logic [NUM_SLOTS-1:0] console_reg, console_next;

    // stage register
    logic                  s1_valid_reg;
    logic [2:0]            s1_req_reg;
    logic                  s1_ok_reg;
    logic [IDX_W-1:0]      s1_idx_reg;
    logic                  s1_console_reg;
    dst_entry_t            s1_alloc_reg;

    // output register
    logic                  out_valid_reg;
    dst_rsp_t              out_reg;

    logic                  in_xfer;
    logic                  s1_move;
    logic                  free_found;
    logic [IDX_W-1:0]      free_idx;
    logic [IDX_W-1:0]      req_idx;
    logic                  idx_in_range;
    logic                  slot_used_ok;
    logic                  is_alloc;
    logic                  ok_next;
    logic [IDX_W-1:0]      idx_next;
    dst_entry_t            alloc_word;
    dst_entry_t            rd_entry;
    dst_entry_t            show_entry;
    logic                  show_console;
    logic [7:0]            idx_wide;
    dst_rsp_t              rsp_next;

    // handshakes
    assign s1_move  = !out_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || s1_move;
    assign in_xfer  = req.valid && req.ready;

    dst_free_enc #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_free_enc (
        .used  (used_reg),
        .found (free_found),
        .idx   (free_idx)
    );

    // index check: negative values read as 128 and above, so one compare does it
    assign idx_in_range = $unsigned(req.slot_number) < 8'(NUM_SLOTS);
    assign req_idx      = req.slot_number[IDX_W-1:0];
    assign slot_used_ok = idx_in_range && used_reg[req_idx];
    assign is_alloc     = (req.req_type == REQ_ALLOC_FILE) ||
                          (req.req_type == REQ_ALLOC_SOCKET);

    // word to store for an allocate
    always_comb
    begin
        alloc_word.is_socket = (req.req_type == REQ_ALLOC_SOCKET);
        if (req.req_type == REQ_ALLOC_SOCKET)
        begin
            alloc_word.word_a = req.socket_number;
            alloc_word.word_b = WORD_ZERO;
        end
        else
        begin
            alloc_word.word_a = req.node_value;
            alloc_word.word_b = req.open_flags;
        end
    end

    // decision and state update for the request being taken
    always_comb
    begin
        used_next    = used_reg;
        console_next = console_reg;
        ok_next      = 1'b0;
        idx_next     = req_idx;
        unique case (req.req_type) inside
            REQ_LOOKUP:
            begin
                ok_next = slot_used_ok;
            end
            REQ_ALLOC_FILE, REQ_ALLOC_SOCKET:
            begin
                ok_next  = free_found;
                idx_next = free_idx;
                if (in_xfer && free_found)
                begin
                    used_next[free_idx]    = 1'b1;
                    console_next[free_idx] = 1'b0;
                end
            end
            REQ_CLOSE:
            begin
                ok_next = slot_used_ok;
                if (in_xfer && slot_used_ok)
                begin
                    used_next[req_idx] = 1'b0;
                end
            end
            REQ_REINIT:
            begin
                ok_next = 1'b1;
                if (in_xfer)
                begin
                    used_next    = INIT_MASK;
                    console_next = INIT_MASK;
                end
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= INIT_MASK;
            console_reg <= INIT_MASK;
        end
        else
        begin
            used_reg    <= used_next;
            console_reg <= console_next;
        end
    end

    // payload memory: allocate writes the granted slot, every transfer reads the named one
    dst_slot_mem #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_slot_mem (
        .clk     (clk),
        .wr_en   (in_xfer && is_alloc && free_found),
        .wr_addr (free_idx),
        .wr_data (alloc_word),
        .rd_en   (in_xfer),
        .rd_addr (req_idx),
        .rd_data (rd_entry)
    );

    // stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_req_reg     <= req.req_type;
            s1_ok_reg      <= ok_next;
            s1_idx_reg     <= idx_next;
            s1_console_reg <= console_reg[req_idx];
            s1_alloc_reg   <= alloc_word;
        end
    end

    // result formation from the stage register
    assign idx_wide = 8'(s1_idx_reg);

    always_comb
    begin
        // allocate reports what it just stored, lookup what the memory holds
        if ((s1_req_reg == REQ_ALLOC_FILE) || (s1_req_reg == REQ_ALLOC_SOCKET))
        begin
            show_entry   = s1_alloc_reg;
            show_console = 1'b0;
        end
        else
        begin
            show_entry   = rd_entry;
            show_console = s1_console_reg;
        end
    end

    always_comb
    begin
        rsp_next                = '0;
        rsp_next.status         = 1'b1;
        if (s1_ok_reg)
        begin
            rsp_next.status = 1'b0;
            case (s1_req_reg) inside
                REQ_LOOKUP, REQ_ALLOC_FILE, REQ_ALLOC_SOCKET:
                begin
                    rsp_next.slot_result = idx_wide[DST_SLOT_OUT_W-1:0];
                    if (show_console)
                    begin
                        rsp_next.entry_kind = KIND_CONSOLE;
                        rsp_next.node_out   = WORD_NEG_ONE;
                        rsp_next.socket_out = WORD_NEG_ONE;
                        rsp_next.flags_out  = WORD_ZERO;
                    end
                    else if (show_entry.is_socket)
                    begin
                        rsp_next.entry_kind = KIND_SOCKET;
                        rsp_next.node_out   = WORD_NEG_ONE;
                        rsp_next.socket_out = show_entry.word_a;
                        rsp_next.flags_out  = WORD_ZERO;
                    end
                    else
                    begin
                        rsp_next.entry_kind = KIND_FILE;
                        rsp_next.node_out   = show_entry.word_a;
                        rsp_next.socket_out = WORD_NEG_ONE;
                        rsp_next.flags_out  = show_entry.word_b;
                    end
                end
                REQ_CLOSE:
                begin
                    rsp_next.slot_result = idx_wide[DST_SLOT_OUT_W-1:0];
                    // only a socket with a non-negative id needs releasing
                    if (!s1_console_reg && rd_entry.is_socket &&
                        !rd_entry.word_a[DST_WORD_W-1])
                    begin
                        rsp_next.socket_out     = rd_entry.word_a;
                        rsp_next.release_socket = 1'b1;
                    end
                end
                default:
                begin
                    // reinitialize: success with every other field zero
                    rsp_next.status = 1'b0;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_valid_reg)
        begin
            out_reg <= rsp_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_reg.status;
    assign rsp.slot_result    = out_reg.slot_result;
    assign rsp.entry_kind     = out_reg.entry_kind;
    assign rsp.node_out       = $signed(out_reg.node_out);
    assign rsp.socket_out     = $signed(out_reg.socket_out);
    assign rsp.flags_out      = out_reg.flags_out;
    assign rsp.release_socket = out_reg.release_socket;

endmodule

// ===== sim/tb_descriptor_slot_table.sv =====
// self-checking testbench for the descriptor slot table
module tb_descriptor_slot_table
    import dst_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // request codes above REQ_REINIT are undefined and must be rejected
    localparam logic [2:0] REQ_UNKNOWN_FIRST = 3'd5;
    localparam logic [2:0] REQ_UNKNOWN_LAST  = 3'd7;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_OFF_LEN  = 80;
    localparam int MAX_PRINTED   = 40;

    // one request as the sender sees it
    typedef struct {
        logic [2:0]         kind;
        logic signed [7:0]  slot;
        logic [31:0]        node;
        logic [31:0]        sock;
        logic [31:0]        flags;
    } request_t;

    logic clk = 1'b0;
    logic rst_n;

    dst_req_if req_ch ();
    dst_rsp_if rsp_ch ();

    descriptor_slot_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of the slot table, updated as each request is accepted
    logic        shadow_used  [DST_NUM_SLOTS];
    logic [1:0]  shadow_kind  [DST_NUM_SLOTS];
    logic [31:0] shadow_node  [DST_NUM_SLOTS];
    logic [31:0] shadow_sock  [DST_NUM_SLOTS];
    logic [31:0] shadow_flags [DST_NUM_SLOTS];

    // results the table owes us, oldest first
    dst_rsp_t pending_results [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_off_left  = 0;
    int cycle_count    = 0;
    int mismatch_count = 0;
    int results_checked = 0;
    int requests_sent  = 0;
    int full_rejects   = 0;
    int slot_rejects   = 0;
    int socket_releases = 0;
    int unknown_rejects = 0;

    // ------------------------------------------------------------------
    // table model
    // ------------------------------------------------------------------

    // back to the power-up picture: everything free except the consoles
    function automatic void shadow_reinit();
        for (int i = 0; i < DST_NUM_SLOTS; i++)
        begin
            shadow_used[i]  = (i < DST_CONSOLE_SLOTS);
            shadow_kind[i]  = (i < DST_CONSOLE_SLOTS) ? KIND_CONSOLE : KIND_NONE;
            shadow_node[i]  = WORD_NEG_ONE;
            shadow_sock[i]  = WORD_NEG_ONE;
            shadow_flags[i] = WORD_ZERO;
        end
    endfunction

    // index of a slot that is in range and in use, or -1
    function automatic int used_index(logic signed [7:0] slot);
        int idx;
        idx = int'(slot);
        if (idx < 0 || idx >= DST_NUM_SLOTS)
            return -1;
        if (!shadow_used[idx])
            return -1;
        return idx;
    endfunction

    // successful result that shows the stored contents of one slot
    function automatic dst_rsp_t show_entry(int idx);
        dst_rsp_t res;
        res             = '0;
        res.slot_result = idx[3:0];
        res.entry_kind  = shadow_kind[idx];
        res.node_out    = shadow_node[idx];
        res.socket_out  = shadow_sock[idx];
        res.flags_out   = shadow_flags[idx];
        return res;
    endfunction

    // apply one request to the shadow table and return the result it owes
    function automatic dst_rsp_t apply_request(request_t r);
        dst_rsp_t res;
        int       idx;
        res        = '0;
        res.status = 1'b1;
        idx        = -1;
        case (r.kind)
            REQ_LOOKUP:
            begin
                idx = used_index(r.slot);
                if (idx >= 0)
                    res = show_entry(idx);
                else
                    slot_rejects++;
            end
            REQ_ALLOC_FILE, REQ_ALLOC_SOCKET:
            begin
                // lowest free slot wins
                for (int i = DST_NUM_SLOTS - 1; i >= 0; i--)
                    if (!shadow_used[i])
                        idx = i;
                if (idx >= 0)
                begin
                    shadow_used[idx] = 1'b1;
                    if (r.kind == REQ_ALLOC_FILE)
                    begin
                        shadow_kind[idx]  = KIND_FILE;
                        shadow_node[idx]  = r.node;
                        shadow_sock[idx]  = WORD_NEG_ONE;
                        shadow_flags[idx] = r.flags;
                    end
                    else
                    begin
                        shadow_kind[idx]  = KIND_SOCKET;
                        shadow_node[idx]  = WORD_NEG_ONE;
                        shadow_sock[idx]  = r.sock;
                        shadow_flags[idx] = WORD_ZERO;
                    end
                    res = show_entry(idx);
                end
                else
                    full_rejects++;
            end
            REQ_CLOSE:
            begin
                idx = used_index(r.slot);
                if (idx >= 0)
                begin
                    res.status      = 1'b0;
                    res.slot_result = idx[3:0];
                    // only a socket with a real (non-negative) id needs releasing
                    if (shadow_kind[idx] == KIND_SOCKET && !shadow_sock[idx][31])
                    begin
                        res.socket_out     = shadow_sock[idx];
                        res.release_socket = 1'b1;
                        socket_releases++;
                    end
                    shadow_used[idx]  = 1'b0;
                    shadow_kind[idx]  = KIND_NONE;
                    shadow_node[idx]  = WORD_NEG_ONE;
                    shadow_sock[idx]  = WORD_NEG_ONE;
                    shadow_flags[idx] = WORD_ZERO;
                end
                else
                    slot_rejects++;
            end
            REQ_REINIT:
            begin
                shadow_reinit();
                res.status = 1'b0;
            end
            default:
                unknown_rejects++;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic request_t make_req(logic [2:0] kind, int slot, logic [31:0] node,
                                          logic [31:0] sock, logic [31:0] flags);
        request_t r;
        r.kind  = kind;
        r.slot  = slot[7:0];
        r.node  = node;
        r.sock  = sock;
        r.flags = flags;
        return r;
    endfunction

    // node and socket words: -1 up to the largest positive value
    function automatic logic [31:0] draw_word();
        logic [31:0] w;
        w = $urandom();
        w[31] = 1'b0;
        case ($urandom_range(0, 9))
            0:       w = WORD_NEG_ONE;
            1:       w = 32'h7fff_ffff;
            2:       w = WORD_ZERO;
            default: ;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] draw_flags();
        case ($urandom_range(0, 9))
            0:       return WORD_ZERO;
            1:       return WORD_NEG_ONE;
            default: return $urandom();
        endcase
    endfunction

    // filling bursts lean on allocates so the table runs full, draining
    // bursts lean on closes so slots get freed and reused
    function automatic request_t draw_request(bit filling);
        request_t r;
        int       roll;
        int       slot_roll;
        int       used_list [$];
        r.kind  = REQ_LOOKUP;
        r.slot  = 8'($urandom());
        r.node  = draw_word();
        r.sock  = draw_word();
        r.flags = draw_flags();
        roll    = $urandom_range(0, 99);
        if (roll < 2)
            r.kind = REQ_REINIT;
        else if (roll < 4)
            r.kind = 3'($urandom_range(REQ_UNKNOWN_FIRST, REQ_UNKNOWN_LAST));
        else if (roll < (filling ? 64 : 19))
            r.kind = $urandom_range(0, 1) ? REQ_ALLOC_FILE : REQ_ALLOC_SOCKET;
        else if (roll < (filling ? 74 : 69))
            r.kind = REQ_CLOSE;
        if (r.kind == REQ_LOOKUP || r.kind == REQ_CLOSE)
        begin
            for (int i = 0; i < DST_NUM_SLOTS; i++)
                if (shadow_used[i])
                    used_list.push_back(i);
            slot_roll = $urandom_range(0, 99);
            if (slot_roll < 60 && used_list.size() > 0)
                r.slot = 8'(used_list[$urandom_range(0, used_list.size() - 1)]);
            else if (slot_roll < 85)
                r.slot = 8'($urandom_range(0, DST_NUM_SLOTS - 1));
            // else keep the full 8-bit random index, mostly out of range
        end
        return r;
    endfunction

    // offer one request, idling first at the current rate, and wait for the
    // transfer; entered and left just after a rising edge
    task automatic send_request(request_t r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= r.kind;
        req_ch.slot_number   <= r.slot;
        req_ch.node_value    <= r.node;
        req_ch.socket_number <= r.sock;
        req_ch.open_flags    <= r.flags;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_results.push_back(apply_request(r));
        requests_sent++;
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] result %0d: %s is %h, expected %h",
                     $realtime, results_checked, what, got, want);
        mismatch_count++;
    endtask

    // receiver: random stalls, plus a counted hold-off when a test asks
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (hold_off_left > 0)
        begin
            rsp_ch.ready  <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end
        else
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // compare every result transfer against the oldest expectation
    always @(posedge clk)
    begin : check_results
        dst_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, status", 32'(rsp_ch.status), 'x);
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
                if (rsp_ch.slot_result !== want.slot_result)
                    report_mismatch("slot_result", 32'(rsp_ch.slot_result),
                                    32'(want.slot_result));
                if (rsp_ch.entry_kind !== want.entry_kind)
                    report_mismatch("entry_kind", 32'(rsp_ch.entry_kind),
                                    32'(want.entry_kind));
                if (rsp_ch.node_out !== want.node_out)
                    report_mismatch("node_out", rsp_ch.node_out, want.node_out);
                if (rsp_ch.socket_out !== want.socket_out)
                    report_mismatch("socket_out", rsp_ch.socket_out, want.socket_out);
                if (rsp_ch.flags_out !== want.flags_out)
                    report_mismatch("flags_out", rsp_ch.flags_out, want.flags_out);
                if (rsp_ch.release_socket !== want.release_socket)
                    report_mismatch("release_socket", 32'(rsp_ch.release_socket),
                                    32'(want.release_socket));
            end
            results_checked++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // power-up contents, index extremes, every request kind and the
    // close cases with and without a socket to release
    task automatic test_directed_ops();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_request(make_req(REQ_LOOKUP, 0, 0, 0, 0));
        send_request(make_req(REQ_LOOKUP, 2, 0, 0, 0));
        send_request(make_req(REQ_LOOKUP, 3, 0, 0, 0));        // free slot
        send_request(make_req(REQ_LOOKUP, -1, 0, 0, 0));       // negative index
        send_request(make_req(REQ_LOOKUP, -128, 0, 0, 0));
        send_request(make_req(REQ_LOOKUP, DST_NUM_SLOTS, 0, 0, 0));
        send_request(make_req(REQ_LOOKUP, 127, 0, 0, 0));
        send_request(make_req(REQ_ALLOC_FILE, 0, 32'h7fff_ffff, 0, WORD_NEG_ONE));
        send_request(make_req(REQ_ALLOC_SOCKET, 0, 0, 32'h7fff_ffff, 0));
        send_request(make_req(REQ_ALLOC_SOCKET, 0, 0, WORD_NEG_ONE, 0));
        send_request(make_req(REQ_ALLOC_SOCKET, 0, 32'h1234_5678, WORD_ZERO, 32'h5a5a));
        send_request(make_req(REQ_ALLOC_FILE, 0, WORD_NEG_ONE, 32'h55, WORD_ZERO));
        send_request(make_req(REQ_LOOKUP, 3, 0, 0, 0));
        send_request(make_req(REQ_LOOKUP, 5, 0, 0, 0));
        send_request(make_req(REQ_CLOSE, 4, 0, 0, 0));         // socket id released
        send_request(make_req(REQ_CLOSE, 5, 0, 0, 0));         // socket id -1, nothing
        send_request(make_req(REQ_CLOSE, 6, 0, 0, 0));         // socket id zero released
        send_request(make_req(REQ_CLOSE, 1, 0, 0, 0));         // console slot
        send_request(make_req(REQ_CLOSE, 1, 0, 0, 0));         // now unused
        send_request(make_req(REQ_CLOSE, -128, 0, 0, 0));
        send_request(make_req(REQ_ALLOC_FILE, 0, 0, 0, 32'ha5a5_0f0f)); // reuses slot 1
        send_request(make_req(REQ_UNKNOWN_FIRST, 3, 0, 0, 0));
        send_request(make_req(REQ_UNKNOWN_LAST, 3, 0, 0, 0));
        send_request(make_req(REQ_REINIT, 0, 0, 0, 0));
        send_request(make_req(REQ_LOOKUP, 3, 0, 0, 0));        // cleared by reinit
    endtask

    // random traffic in alternating fill and drain bursts
    task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
        bit filling;
        filling        = 1'b1;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
        begin
            if (n % 24 == 23)
                filling = !filling;
            send_request(draw_request(filling));
        end
    endtask

    // hold the result side off long enough that the table backs up and
    // stops taking requests, while requests keep coming
    task automatic test_result_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_left  = HOLD_OFF_LEN;
        for (int n = 0; n < 40; n++)
            send_request(draw_request(n < 20));
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.req_type      = REQ_LOOKUP;
        req_ch.slot_number   = '0;
        req_ch.node_value    = '0;
        req_ch.socket_number = '0;
        req_ch.open_flags    = '0;
        rsp_ch.ready         = 1'b0;
        shadow_reinit();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_ops();
        test_random_traffic(480, 33, 80);
        test_random_traffic(480, 80, 33);
        test_result_backpressure();
        test_random_traffic(450, 0, 0);

        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests, %0d results checked in %0d cycles",
                 requests_sent, results_checked, cycle_count);
        $display("rejects: table full %0d, bad or free slot %0d, unknown %0d; releases %0d",
                 full_rejects, slot_rejects, unknown_rejects, socket_releases);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
